/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled in rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define HB_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// pre at one edge implies post at the next
`define HB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* design/hb27_pkg.sv */
// ---------------------------------------------------------------------------
// hb27_pkg
// Types and constants of the 27-tap halfband interpolator.
// ---------------------------------------------------------------------------
package hb27_pkg;

  localparam int COEF_W      = 16;
  localparam int NUM_REGS    = 8;
  localparam int NUM_SYM     = 7;
  localparam int HIST_DEPTH  = 13;
  localparam int CENTER_TAP  = 6;
  localparam int OUT_SHIFT   = 15;
  localparam int CFG_INDEX_W = 4;
  localparam int COEF_SEL_W  = 3;

  typedef logic signed [COEF_W-1:0] coef_t;

  // register index of the centre tap
  localparam logic [COEF_SEL_W-1:0] REG_CENTER = 3'd7;

  localparam coef_t COEF_RESET [NUM_REGS] = '{
    16'sd33, -16'sd158, 16'sd491, -16'sd1214,
    16'sd2674, -16'sd5942, 16'sd20503, 16'sd32767
  };

endpackage

/* design/hb27_in_if.sv */
// ---------------------------------------------------------------------------
// hb27_in_if
// Complex sample channel, valid/ready.
// ---------------------------------------------------------------------------
interface hb27_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_re;
  logic signed [SAMPLE_WIDTH-1:0] in_im;

  modport source (output valid, output in_re, output in_im, input ready);
  modport sink (input valid, input in_re, input in_im, output ready);
endinterface

/* design/hb27_out_if.sv */
// ---------------------------------------------------------------------------
// hb27_out_if
// Complex result channel with phase marker, valid/ready.
// ---------------------------------------------------------------------------
interface hb27_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_re;
  logic signed [SAMPLE_WIDTH-1:0] out_im;
  logic                           last;

  modport source (output valid, output out_re, output out_im, output last, input ready);
  modport sink (input valid, input out_re, input out_im, input last, output ready);
endinterface

/* design/halfband_fir27_interpolate_by_two.sv */
// Path: window, product, sum and result-pair registers; the even-phase beat of
// each sample goes out before its odd-phase beat. The result channel moves two
// beats per sample; unless held by it, the pipeline takes a sample every cycle.
// Reset (rst, synchronous): history cleared to zero, coefficients to defaults,
// pipeline emptied.
// ---------------------------------------------------------------------------
// halfband_fir27_interpolate_by_two
// Complex 27-tap halfband FIR, interpolation by two: symmetric-sum phase then
// centre-tap phase for each input sample.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module halfband_fir27_interpolate_by_two #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [hb27_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [hb27_pkg::COEF_W-1:0]        cfg_data,
  hb27_in_if.sink                            samples,
  hb27_out_if.source                         results
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int PROD_W = W + 1 + hb27_pkg::COEF_W;
  localparam int CTR_W  = W + hb27_pkg::COEF_W;
  localparam int SUM_W  = PROD_W + 3;
  localparam int Q_W    = SUM_W + 1 - hb27_pkg::OUT_SHIFT;
  localparam int NTAPS  = hb27_pkg::HIST_DEPTH + 1;

  localparam logic signed [SUM_W:0] RND  = (SUM_W+1)'(1) <<< (hb27_pkg::OUT_SHIFT - 1);
  localparam logic signed [Q_W-1:0] QMAX = Q_W'((1 << (W - 1)) - 1);
  localparam logic signed [Q_W-1:0] QMIN = -QMAX - Q_W'(1);

  function automatic logic signed [W-1:0] round_sat(input logic signed [SUM_W-1:0] a);
    logic signed [SUM_W:0]  t;
    logic signed [Q_W-1:0]  q;
    t = (SUM_W+1)'(a) + RND;
    q = t[SUM_W:hb27_pkg::OUT_SHIFT];
    if (q > QMAX) begin
      q = QMAX;
    end else if (q < QMIN) begin
      q = QMIN;
    end
    return q[W-1:0];
  endfunction

  hb27_pkg::coef_t coef [hb27_pkg::NUM_REGS];

  // taps[0] = x[n], taps[k] = x[n-k]
  logic signed [W-1:0] taps_re [NTAPS];
  logic signed [W-1:0] taps_im [NTAPS];

  logic signed [PROD_W-1:0] prod_re [hb27_pkg::NUM_SYM];
  logic signed [PROD_W-1:0] prod_im [hb27_pkg::NUM_SYM];
  logic signed [PROD_W-1:0] prod_re_next [hb27_pkg::NUM_SYM];
  logic signed [PROD_W-1:0] prod_im_next [hb27_pkg::NUM_SYM];
  logic signed [CTR_W-1:0]  ctr_re, ctr_im, ctr2_re, ctr2_im;
  logic signed [SUM_W-1:0]  sum_re, sum_im, sum_re_next, sum_im_next;

  logic signed [W-1:0] even_re, even_im, odd_re, odd_im;
  logic                phase;

  logic v1, v2, v3, v4;
  logic in_fire, out_fire, adv1, adv2, adv3, pair_take;

  assign in_fire   = samples.valid && samples.ready;
  assign out_fire  = results.valid && results.ready;
  assign pair_take = !v4 || (phase && results.ready);
  assign adv3      = v3 && pair_take;
  assign adv2      = v2 && (!v3 || adv3);
  assign adv1      = v1 && (!v2 || adv2);
  assign samples.ready = !v1 || adv1;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hb27_pkg::NUM_REGS; i++) begin
        coef[i] <= hb27_pkg::COEF_RESET[i];
      end
    end else if (cfg_we && (cfg_index < hb27_pkg::CFG_INDEX_W'(hb27_pkg::NUM_REGS))) begin
      coef[cfg_index[hb27_pkg::COEF_SEL_W-1:0]] <= cfg_data;
    end
  end

  // sample window
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NTAPS; i++) begin
        taps_re[i] <= '0;
        taps_im[i] <= '0;
      end
    end else if (in_fire) begin
      taps_re[0] <= samples.in_re;
      taps_im[0] <= samples.in_im;
      for (int i = 1; i < NTAPS; i++) begin
        taps_re[i] <= taps_re[i-1];
        taps_im[i] <= taps_im[i-1];
      end
    end
  end

  // pre-add and multiply
  always_comb begin
    logic signed [W:0] pre_re, pre_im;
    for (int k = 0; k < hb27_pkg::NUM_SYM; k++) begin
      pre_re = (W+1)'(taps_re[k]) + (W+1)'(taps_re[hb27_pkg::HIST_DEPTH-k]);
      pre_im = (W+1)'(taps_im[k]) + (W+1)'(taps_im[hb27_pkg::HIST_DEPTH-k]);
      prod_re_next[k] = PROD_W'(coef[k]) * PROD_W'(pre_re);
      prod_im_next[k] = PROD_W'(coef[k]) * PROD_W'(pre_im);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      prod_re <= prod_re_next;
      prod_im <= prod_im_next;
      ctr_re  <= CTR_W'(coef[hb27_pkg::REG_CENTER]) *
                 CTR_W'(taps_re[hb27_pkg::CENTER_TAP]);
      ctr_im  <= CTR_W'(coef[hb27_pkg::REG_CENTER]) *
                 CTR_W'(taps_im[hb27_pkg::CENTER_TAP]);
    end
  end

  // symmetric sum
  always_comb begin
    sum_re_next = '0;
    sum_im_next = '0;
    for (int k = 0; k < hb27_pkg::NUM_SYM; k++) begin
      sum_re_next = sum_re_next + SUM_W'(prod_re[k]);
      sum_im_next = sum_im_next + SUM_W'(prod_im[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      sum_re  <= sum_re_next;
      sum_im  <= sum_im_next;
      ctr2_re <= ctr_re;
      ctr2_im <= ctr_im;
    end
  end

  // result pair, even phase first
  always_ff @(posedge clk) begin
    if (adv3) begin
      even_re <= round_sat(sum_re);
      even_im <= round_sat(sum_im);
      odd_re  <= round_sat(SUM_W'(ctr2_re));
      odd_im  <= round_sat(SUM_W'(ctr2_im));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (in_fire) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
      if (adv2) begin
        v3 <= 1'b1;
      end else if (adv3) begin
        v3 <= 1'b0;
      end
      if (adv3) begin
        v4    <= 1'b1;
        phase <= 1'b0;
      end else if (out_fire) begin
        if (phase) begin
          v4    <= 1'b0;
          phase <= 1'b0;
        end else begin
          phase <= 1'b1;
        end
      end
    end
  end

  assign results.valid  = v4;
  assign results.last   = phase;
  assign results.out_re = phase ? odd_re : even_re;
  assign results.out_im = phase ? odd_im : even_im;

  `HB_ASSERT_NEXT(a_odd_follows_even, out_fire && !results.last, results.valid && results.last, "even beat not followed by odd beat")
  `HB_ASSERT_NEXT(a_in_lands, in_fire, v1, "accepted sample lost at window stage")
  `HB_ASSERT_NEXT(a_sum_moves, v3 && !v4, v4, "sum not moved into free result pair")

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the 27-tap halfband interpolator. Complex samples are fed
// through the input channel with random gaps. Both phases of each sample are
// predicted from a local copy of the coefficients and the sample history,
// then checked field by field against the result beats, which arrive under
// random back-pressure. Coefficients change between drained phases.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int SW = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam longint OUT_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
  } sample_t;

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 last;
  } phase_out_t;

  typedef enum {
    COEF_DEFAULT, COEF_FULL, COEF_MODEST, COEF_EXTREME, COEF_MAX, COEF_MIN
  } coef_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [hb27_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [hb27_pkg::COEF_W-1:0] cfg_data;

  hb27_in_if #(.SAMPLE_WIDTH(SW)) smp ();
  hb27_out_if #(.SAMPLE_WIDTH(SW)) res ();

  halfband_fir27_interpolate_by_two #(.SAMPLE_WIDTH(SW)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (smp),
    .results   (res)
  );

  always #6 clk = ~clk;

  // predictor state
  hb27_pkg::coef_t coef_model [hb27_pkg::NUM_REGS];
  logic signed [SW-1:0] hist_re [hb27_pkg::HIST_DEPTH];
  logic signed [SW-1:0] hist_im [hb27_pkg::HIST_DEPTH];

  sample_t    sample_q [$];
  phase_out_t predicted_phases [$];

  int n_samples, n_checked, n_clipped, n_sets, mismatches, stuck_cycles;
  bit in_taken, idle_on, hold_request;
  int gap_left, stall_left, hold_left;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SW-1:0] round_clip(longint acc);
    longint q;
    q = (acc + (longint'(1) <<< (hb27_pkg::OUT_SHIFT - 1))) >>> hb27_pkg::OUT_SHIFT;
    if (q > OUT_MAX) begin
      q = OUT_MAX;
      n_clipped++;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
      n_clipped++;
    end
    return q[SW-1:0];
  endfunction

  function automatic void filter_sample(sample_t s);
    logic signed [SW-1:0] wr [hb27_pkg::HIST_DEPTH+1];
    logic signed [SW-1:0] wi [hb27_pkg::HIST_DEPTH+1];
    longint acc_re, acc_im;
    phase_out_t o;
    wr[0] = s.re;
    wi[0] = s.im;
    for (int k = 0; k < hb27_pkg::HIST_DEPTH; k++) begin
      wr[k+1] = hist_re[k];
      wi[k+1] = hist_im[k];
    end
    acc_re = 0;
    acc_im = 0;
    for (int k = 0; k < hb27_pkg::NUM_SYM; k++) begin
      acc_re += longint'(coef_model[k]) *
                (longint'(wr[k]) + longint'(wr[hb27_pkg::HIST_DEPTH-k]));
      acc_im += longint'(coef_model[k]) *
                (longint'(wi[k]) + longint'(wi[hb27_pkg::HIST_DEPTH-k]));
    end
    o.re = round_clip(acc_re);
    o.im = round_clip(acc_im);
    o.last = 1'b0;
    predicted_phases.push_back(o);
    o.re = round_clip(longint'(coef_model[hb27_pkg::REG_CENTER]) *
                      longint'(wr[hb27_pkg::CENTER_TAP]));
    o.im = round_clip(longint'(coef_model[hb27_pkg::REG_CENTER]) *
                      longint'(wi[hb27_pkg::CENTER_TAP]));
    o.last = 1'b1;
    predicted_phases.push_back(o);
    for (int k = hb27_pkg::HIST_DEPTH - 1; k > 0; k--) begin
      hist_re[k] = hist_re[k-1];
      hist_im[k] = hist_im[k-1];
    end
    hist_re[0] = wr[0];
    hist_im[0] = wi[0];
  endfunction

  // monitor, predictor and watchdog
  phase_out_t want;
  bit out_taken;

  always @(posedge clk) begin
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (rst) begin
      coef_model = hb27_pkg::COEF_RESET;
      for (int k = 0; k < hb27_pkg::HIST_DEPTH; k++) begin
        hist_re[k] = '0;
        hist_im[k] = '0;
      end
      stuck_cycles = 0;
    end else begin
      if (cfg_we && cfg_index < hb27_pkg::NUM_REGS)
        coef_model[cfg_index[hb27_pkg::COEF_SEL_W-1:0]] = cfg_data;
      if (smp.valid && smp.ready) begin
        sample_t s;
        s.re = smp.in_re;
        s.im = smp.in_im;
        in_taken = 1'b1;
        n_samples++;
        filter_sample(s);
      end
      if (res.valid && res.ready) begin
        out_taken = 1'b1;
        if (predicted_phases.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected beat re=%0d im=%0d last=%0b", $realtime,
                     res.out_re, res.out_im, res.last);
          mismatches++;
        end else begin
          want = predicted_phases.pop_front();
          n_checked++;
          if (res.out_re !== want.re || res.out_im !== want.im || res.last !== want.last) begin
            if (mismatches < 10)
              $display("%0t: beat %0d expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                       $realtime, n_checked, want.re, want.im, want.last,
                       res.out_re, res.out_im, res.last);
            mismatches++;
          end
        end
      end
      if ((sample_q.size() != 0 || smp.valid || predicted_phases.size() != 0) &&
          !in_taken && !out_taken)
        stuck_cycles++;
      else
        stuck_cycles = 0;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d outputs outstanding",
                 stuck_cycles, predicted_phases.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // sample driver
  sample_t cur;
  bit offer;

  always @(negedge clk) begin
    if (rst) begin
      smp.valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = smp.valid && !in_taken;
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() != 0) begin
          cur = sample_q.pop_front();
          smp.in_re <= cur.re;
          smp.in_im <= cur.im;
          offer = 1'b1;
          gap_left = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        end
      end
      smp.valid <= offer;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (sample_q.size() != 0 || smp.valid || predicted_phases.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [hb27_pkg::COEF_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[hb27_pkg::CFG_INDEX_W-1:0];
    cfg_data <= data;
  endtask

  task automatic load_coefs(coef_mode_t mode);
    hb27_pkg::coef_t c;
    wait_drained();
    for (int i = 0; i < hb27_pkg::NUM_REGS; i++) begin
      case (mode)
        COEF_DEFAULT: c = hb27_pkg::COEF_RESET[i];
        COEF_FULL:    c = 16'($urandom());
        COEF_MODEST:  c = 16'($urandom_range(0, 8191) - 4096);
        COEF_MAX:     c = 16'sh7fff;
        COEF_MIN:     c = 16'sh8000;
        default: begin
          case ($urandom_range(0, 4))
            0: c = 16'sh7fff;
            1: c = 16'sh8000;
            2: c = 16'sd0;
            3: c = -16'sd1;
            default: c = 16'sd1;
          endcase
        end
      endcase
      write_reg(i, c);
    end
    // out-of-range index, must leave the taps alone
    write_reg(hb27_pkg::NUM_REGS + $urandom_range(0, 7), 16'($urandom()));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_sets++;
  endtask

  function automatic void push_sample(logic signed [SW-1:0] re, logic signed [SW-1:0] im);
    sample_t s;
    s.re = re;
    s.im = im;
    sample_q.push_back(s);
  endfunction

  function automatic logic signed [SW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      1, 2: return 16'($urandom_range(0, 511) - 256);
      3: return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom());
    endcase
  endfunction

  coef_mode_t plan [8] = '{COEF_FULL, COEF_MODEST, COEF_DEFAULT, COEF_EXTREME,
                           COEF_MODEST, COEF_FULL, COEF_DEFAULT, COEF_MODEST};

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.in_re = '0;
    smp.in_im = '0;
    res.ready = 1'b0;
    idle_on = 1'b1;
    hold_request = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset taps, start-up from cleared history, field extremes
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh8000, 16'sh7fff);
    push_sample(16'sd0, 16'sd0);
    push_sample(-16'sd1, 16'sd1);
    push_sample(16'sd1, -16'sd1);
    push_sample(16'sh7fff, 16'sh7fff);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(16'sh5555, 16'shaaaa);
    for (int i = 0; i < 6; i++)
      push_sample(i[0] ? 16'shaaaa : 16'sh5555, i[0] ? 16'sh5555 : 16'shaaaa);

    // clipping of the symmetric sum both ways
    load_coefs(COEF_MAX);
    repeat (4) push_sample(16'sh7fff, 16'sh8000);

    // clipping of the centre tap as well
    load_coefs(COEF_MIN);
    repeat (7) push_sample(16'sh8000, 16'sh7fff);

    for (int p = 0; p < 8; p++) begin
      load_coefs(plan[p]);
      idle_on = (p != 6);
      for (int i = 0; i < 165; i++)
        push_sample(rand_value(), rand_value());
      if (p == 7) begin
        @(posedge clk);
        hold_request = 1'b1;
      end
    end

    wait_drained();
    $display("%0d samples filtered, %0d output beats checked, %0d clipped parts",
             n_samples, n_checked, n_clipped);
    $display("%0d tap sets including extremes, one long output hold, %0d mismatches",
             n_sets, mismatches);
    if (mismatches == 0 && predicted_phases.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* halfband_fir27_interpolate_by_two.f */
+incdir+design
design/hb27_pkg.sv
design/hb27_in_if.sv
design/hb27_out_if.sv
design/halfband_fir27_interpolate_by_two.sv
tb/sv/tb_top.sv
